FILE: hdl/utf8_validating_decoder_core_assert.svh
// Assertion macros for the UTF-8 decoder core.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define UVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define UVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/utf8vd_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// No dependencies; imported by utf8vd_decode and the core top level.
`default_nettype none

package utf8vd_pkg;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;

  // Default depth of the result queue in the core
  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Pending partial sequence
  typedef struct packed {
    logic [7:0]      lead;
    logic [1:0]      held;
    logic [CP_W-1:0] partial;
  } state_t;

  // One result word
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             ill_formed;
    logic [CNT_W-1:0] consumed_bytes;
    logic             last_in_run;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/utf8vd_decode.sv
// Combinational per-byte UTF-8 decode step: next pending state and up to two results.
// Depends on utf8vd_pkg.
`default_nettype none

module utf8vd_decode
  import utf8vd_pkg::*;
(
  input  state_t     state,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output state_t     state_nxt,
  output logic [1:0] num_res,
  output result_t    res0,
  output result_t    res1
);

  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_LO_E0 = 8'hA0;
  localparam logic [7:0] CONT_HI_ED = 8'h9F;
  localparam logic [7:0] CONT_LO_F0 = 8'h90;
  localparam logic [7:0] CONT_HI_F4 = 8'h8F;

  typedef struct packed {
    logic    emit;
    result_t res;
    state_t  st;
  } lead_out_t;

  // Examine a byte as the start of a sequence
  function automatic lead_out_t take_lead(input logic [7:0] b);
    lead_out_t o;
    o.emit = 1'b0;
    o.res  = '{code_point: REPLACEMENT_CP, ill_formed: 1'b1,
               consumed_bytes: CNT_W'(1), last_in_run: 1'b1};
    o.st   = '0;
    if (b < CONT_LO) begin
      o.emit = 1'b1;
      o.res.code_point = CP_W'(b);
      o.res.ill_formed = 1'b0;
    end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
      o.st = '{lead: b, held: 2'd1, partial: CP_W'(b[4:0])};
    end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
      o.st = '{lead: b, held: 2'd1, partial: CP_W'(b[3:0])};
    end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
      o.st = '{lead: b, held: 2'd1, partial: CP_W'(b[2:0])};
    end else begin
      o.emit = 1'b1;  // forbidden lead byte
    end
    return o;
  endfunction

  lead_out_t        lead_res;
  logic [7:0]       cont_lo;
  logic [7:0]       cont_hi;
  logic             cont_ok;
  logic [CNT_W-1:0] seq_len;
  logic [CNT_W-1:0] held_inc;
  logic [CP_W-1:0]  partial_shift;
  result_t          flush_res;

  assign lead_res = take_lead(data_byte);

  // Allowed continuation range, narrowed on the second byte after some leads
  always_comb begin
    cont_lo = CONT_LO;
    cont_hi = CONT_HI;
    if (state.held == 2'd1) begin
      case (state.lead)
        LEAD3_LO: cont_lo = CONT_LO_E0;
        LEAD_ED:  cont_hi = CONT_HI_ED;
        LEAD4_LO: cont_lo = CONT_LO_F0;
        LEAD4_HI: cont_hi = CONT_HI_F4;
        default: ;
      endcase
    end
  end

  assign cont_ok = (data_byte >= cont_lo) && (data_byte <= cont_hi);

  // Sequence length implied by the held lead
  assign seq_len = (state.lead < LEAD3_LO) ? CNT_W'(2) :
                   (state.lead < LEAD4_LO) ? CNT_W'(3) : CNT_W'(4);

  assign held_inc      = CNT_W'(state.held) + CNT_W'(1);
  assign partial_shift = {state.partial[CP_W-7:0], data_byte[5:0]};

  // Replacement for the pending bad prefix
  assign flush_res = '{code_point: REPLACEMENT_CP, ill_formed: 1'b1,
                       consumed_bytes: CNT_W'(state.held), last_in_run: 1'b1};

  always_comb begin
    state_nxt = state;
    num_res   = 2'd0;
    res0      = flush_res;
    res1      = lead_res.res;
    if (end_of_text) begin
      state_nxt = '0;
      if (state.held != 2'd0) begin
        num_res = 2'd1;
      end
    end else if (state.held == 2'd0) begin
      state_nxt = lead_res.st;
      res0      = lead_res.res;
      num_res   = {1'b0, lead_res.emit};
    end else if (cont_ok) begin
      // Gather six more bits; complete once the length is reached
      if (held_inc >= seq_len) begin
        state_nxt = '0;
        num_res   = 2'd1;
        res0      = '{code_point: partial_shift, ill_formed: 1'b0,
                      consumed_bytes: seq_len, last_in_run: 1'b1};
      end else begin
        state_nxt.held    = held_inc[1:0];
        state_nxt.partial = partial_shift;
      end
    end else begin
      // Bad continuation: flush prefix, then retry the byte as a lead
      state_nxt = lead_res.st;
      if (lead_res.emit) begin
        num_res          = 2'd2;
        res0.last_in_run = 1'b0;
      end else begin
        num_res = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/utf8_validating_decoder_core.sv
// UTF-8 validating decoder core: input register, decode step, result queue.
// A byte passes from the input register through the result queue to the output.
// Throughput: one byte per cycle while the result queue has room; a byte that
//   yields two results is absorbed by the result queue (FIFO_DEPTH words).
// Reset: synchronous active-low rst_n clears the pending sequence, the input
//   register valid and the queue pointers; queued payload is not cleared.
// Depends on utf8vd_pkg and utf8vd_decode.
`default_nettype none
`include "utf8_validating_decoder_core_assert.svh"

module utf8_validating_decoder_core
  import utf8vd_pkg::*;
#(
  parameter int FIFO_DEPTH = RES_FIFO_DEPTH  // at least 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] consumed_bytes
  output logic        out_tuser,  // [0] ill_formed
  output logic        out_tlast   // last result caused by an input word
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FIRE_MAX  = CNT_W_Q'(FIFO_DEPTH - 2);
  localparam logic [CNT_W_Q-1:0] DEPTH_CNT = CNT_W_Q'(FIFO_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  // Decode state and results
  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] num_res;
  result_t    res0;
  result_t    res1;
  logic       fire;

  // Result queue
  result_t             queue_r [FIFO_DEPTH];
  logic [PTR_W-1:0]    head_r;
  logic [PTR_W-1:0]    tail_r;
  logic [PTR_W-1:0]    tail_inc;
  logic [CNT_W_Q-1:0]  count_r;
  logic                pop;
  result_t             head_res;

  // Decode fires only when the queue has room for two words
  assign fire      = in_valid_r && (count_r <= FIRE_MAX);
  assign in_tready = !in_valid_r || fire;
  assign pop       = out_tvalid && out_tready;
  assign tail_inc  = ptr_inc(tail_r);

  utf8vd_decode u_decode (
    .state       (state_r),
    .data_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .state_nxt   (state_nxt),
    .num_res     (num_res),
    .res0        (res0),
    .res1        (res1)
  );

  // Input register and pending-sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tuser;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        head_r <= ptr_inc(head_r);
      end
      if (fire) begin
        case (num_res)
          2'd1:    tail_r <= tail_inc;
          2'd2:    tail_r <= ptr_inc(tail_inc);
          default: ;
        endcase
      end
      count_r <= count_r + (fire ? CNT_W_Q'(num_res) : '0) - CNT_W_Q'(pop);
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (fire && (num_res != 2'd0)) begin
      queue_r[tail_r] <= res0;
    end
    if (fire && (num_res == 2'd2)) begin
      queue_r[tail_inc] <= res1;
    end
  end

  // Output word
  assign head_res   = queue_r[head_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {head_res.consumed_bytes, head_res.code_point};
  assign out_tuser  = head_res.ill_formed;
  assign out_tlast  = head_res.last_in_run;

  // Checks
  `UVD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_CNT,
                  "result queue overflow")
  `UVD_ASSERT_NOW(a_fire_room, fire, count_r <= FIRE_MAX,
                  "decode fired without queue room")
  `UVD_ASSERT_NOW(a_bad_is_fffd, out_tvalid && out_tuser,
                  out_tdata[20:0] == REPLACEMENT_CP, "ill-formed word not U+FFFD")
  `UVD_ASSERT_NOW(a_scalar_ok, out_tvalid && !out_tuser,
                  (out_tdata[20:0] <= 21'h10FFFF) &&
                  ((out_tdata[20:0] < 21'h00D800) || (out_tdata[20:0] > 21'h00DFFF)),
                  "decoded value is not a scalar value")
  `UVD_ASSERT_NOW(a_count_range, out_tvalid,
                  (out_tdata[23:21] != 3'd0) && (out_tdata[23:21] <= 3'd4),
                  "consumed byte count out of range")
  `UVD_ASSERT_NEXT(a_two_room, fire && (num_res == 2'd2),
                   count_r >= CNT_W_Q'(2) - CNT_W_Q'($past(pop)),
                   "second result word lost")

endmodule

`default_nettype wire

FILE: test/tb_utf8_validating_decoder_core.sv
// Testbench for utf8_validating_decoder_core: byte stream in, decoded scalar words out.
// Uses a predictor of the decoder and a result checker; depends on utf8vd_pkg and the core.
`timescale 1ns / 100ps

module tb_utf8_validating_decoder_core;
  import utf8vd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 20;

  // Byte classes of UTF-8
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_SURR  = 8'hED;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] consumed_bytes
  logic        out_tuser;  // [0] ill_formed
  logic        out_tlast;

  // Predictor state: the pending partial sequence
  logic [7:0]      pend_lead;
  logic [1:0]      pend_count;
  logic [CP_W-1:0] pend_bits;

  result_t step_results[$];
  result_t expected_results[$];

  int error_count;
  int cycle_count;
  int words_sent;
  int in_gap_max;
  int out_stall_max;
  int hold_off_req;

  utf8_validating_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic result_t make_result(input logic [CP_W-1:0] cp, input logic bad,
                                          input logic [CNT_W-1:0] cnt);
    result_t r;
    r.code_point     = cp;
    r.ill_formed     = bad;
    r.consumed_bytes = cnt;
    r.last_in_run    = 1'b0;
    return r;
  endfunction

  function automatic void clear_pending();
    pend_lead  = 8'h00;
    pend_count = 2'd0;
    pend_bits  = '0;
  endfunction

  // Byte seen with nothing pending: emit ASCII, hold a lead, or reject it
  function automatic void decode_lead(input logic [7:0] b);
    if (b <= ASCII_MAX) begin
      step_results.push_back(make_result({13'd0, b}, 1'b0, 3'd1));
    end else if (b >= LEAD2_MIN && b <= LEAD4_MAX) begin
      pend_lead  = b;
      pend_count = 2'd1;
      if (b <= LEAD2_MAX) pend_bits = {16'd0, b[4:0]};
      else if (b <= LEAD3_MAX) pend_bits = {17'd0, b[3:0]};
      else pend_bits = {18'd0, b[2:0]};
    end else begin
      step_results.push_back(make_result(REPLACEMENT_CP, 1'b1, 3'd1));
    end
  endfunction

  // Expected words for one accepted input word
  function automatic void predict_decode(input logic [7:0] b, input logic eot);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] seq_len;
    logic [1:0] next_count;
    result_t    r;
    step_results.delete();
    if (eot) begin
      if (pend_count != 2'd0)
        step_results.push_back(make_result(REPLACEMENT_CP, 1'b1, {1'b0, pend_count}));
      clear_pending();
    end else if (pend_count == 2'd0) begin
      decode_lead(b);
    end else begin
      lo = CONT_MIN;
      hi = CONT_MAX;
      // narrower second byte after E0, ED, F0 and F4
      if (pend_count == 2'd1) begin
        if (pend_lead == LEAD3_MIN) lo = 8'hA0;
        else if (pend_lead == LEAD_SURR) hi = 8'h9F;
        else if (pend_lead == LEAD4_MIN) lo = 8'h90;
        else if (pend_lead == LEAD4_MAX) hi = 8'h8F;
      end
      if (pend_lead < LEAD3_MIN) seq_len = 3'd2;
      else if (pend_lead < LEAD4_MIN) seq_len = 3'd3;
      else seq_len = 3'd4;
      if (b >= lo && b <= hi) begin
        pend_bits  = {pend_bits[14:0], b[5:0]};
        next_count = pend_count + 2'd1;
        if (next_count == 2'd0 || {1'b0, next_count} >= seq_len) begin
          step_results.push_back(make_result(pend_bits, 1'b0, seq_len));
          clear_pending();
        end else begin
          pend_count = next_count;
        end
      end else begin
        // bad prefix first, then the breaking byte as a new lead
        step_results.push_back(make_result(REPLACEMENT_CP, 1'b1, {1'b0, pend_count}));
        clear_pending();
        decode_lead(b);
      end
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last_in_run = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // Offer one word after a random gap; returns at the edge it is taken
  task automatic send_word(input logic [7:0] b, input logic eot);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_decode(b, eot);
    words_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i], 1'b0);
  endtask

  // One random sequence: mostly well-formed, some truncated, some noise
  task automatic send_random_sequence();
    int         kind;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 11) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind < 35) begin
      send_word(8'($urandom_range(0, ASCII_MAX)), 1'b0);
    end else begin
      len = $urandom_range(2, 4);
      case (len)
        2: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
        3: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
        default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
      endcase
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (lead == LEAD3_MIN) lo = 8'hA0;
      else if (lead == LEAD_SURR) hi = 8'h9F;
      else if (lead == LEAD4_MIN) lo = 8'h90;
      else if (lead == LEAD4_MAX) hi = 8'h8F;
      cut = (kind >= 85) ? $urandom_range(1, len - 1) : len;
      send_word(lead, 1'b0);
      for (int i = 1; i < cut; i++) begin
        if (i == 1) send_word(8'($urandom_range(lo, hi)), 1'b0);
        else send_word(8'($urandom_range(CONT_MIN, CONT_MAX)), 1'b0);
      end
      // truncated: end of text or an arbitrary breaking byte
      if (cut < len) begin
        if ($urandom_range(0, 3) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
        else send_word(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) send_random_sequence();
  endtask

  task automatic test_valid_sequences();
    send_bytes('{8'h00, 8'h7F});
    send_bytes('{8'hDF, 8'hBF});
    send_bytes('{8'hE0, 8'hA0, 8'h80});
    send_bytes('{8'hED, 8'h9F, 8'hBF});
    send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
  endtask

  task automatic test_forbidden_leads();
    send_bytes('{8'h80, 8'hC1, 8'hF5});
  endtask

  task automatic test_bad_continuations();
    // second byte below range after E0, itself a forbidden lead: two results
    send_bytes('{8'hE0, 8'h9F});
    // breaking byte is ASCII
    send_bytes('{8'hC2, 8'h41});
  endtask

  task automatic test_end_of_text();
    send_bytes('{8'hF1, 8'h80, 8'h80});
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_random_idling();
    in_gap_max    = 9;
    out_stall_max = 9;
    run_random(900);
  endtask

  task automatic test_full_rate();
    in_gap_max    = 0;
    out_stall_max = 0;
    run_random(400);
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    in_gap_max    = 0;
    out_stall_max = 0;
    hold_off_req  = 300;
    run_random(150);
  endtask

  task automatic test_slow_sender();
    in_gap_max    = 9;
    out_stall_max = 0;
    run_random(250);
    in_gap_max    = 0;
    out_stall_max = 9;
    run_random(200);
  endtask

  // Result receiver with random stalls and an optional long hold-off
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
      end
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && hold_off_req == 0) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code_point     = out_tdata[CP_W-1:0];
      got.consumed_bytes = out_tdata[CP_W+CNT_W-1:CP_W];
      got.ill_formed     = out_tuser;
      got.last_in_run    = out_tlast;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word cp=%h bad=%b cnt=%0d last=%b", $time,
                 got.code_point, got.ill_formed, got.consumed_bytes, got.last_in_run);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected cp=%h bad=%b cnt=%0d last=%b, got cp=%h bad=%b cnt=%0d last=%b",
                   $time, want.code_point, want.ill_formed, want.consumed_bytes,
                   want.last_in_run, got.code_point, got.ill_formed, got.consumed_bytes,
                   got.last_in_run);
          error_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_tuser      = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    words_sent    = 0;
    in_gap_max    = 3;
    out_stall_max = 3;
    hold_off_req  = 0;
    clear_pending();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_valid_sequences();
    test_forbidden_leads();
    test_bad_continuations();
    test_end_of_text();
    test_random_idling();
    test_full_rate();
    test_backpressure();
    test_slow_sender();

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
